// ===== rtl/feature_hash_bucket_unit_assert.svh =====
// Assertion macros shared by the feature hash bucket RTL.
`ifndef FEATURE_HASH_BUCKET_UNIT_ASSERT_SVH
`define FEATURE_HASH_BUCKET_UNIT_ASSERT_SVH

// Implication checked every clock edge outside reset.
`define FHB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define FHB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fhb_pkg.sv =====
`default_nettype none
package fhb_pkg;
    localparam int LengthBits = 32;
    localparam logic [31:0] MhC1  = 32'hcc9e2d51;
    localparam logic [31:0] MhC2  = 32'h1b873593;
    localparam logic [31:0] MhAdd = 32'he6546b64;
    localparam logic [31:0] MhF1  = 32'h85ebca6b;
    localparam logic [31:0] MhF2  = 32'hc2b2ae35;
    localparam logic [31:0] NumBucketsReset = 32'd8388608;
    localparam logic [63:0] PosLimit = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NegLimit = 64'h8000_0000_0000_0000;

    localparam logic [0:0] CfgNumBuckets = 1'b0;
    localparam logic [0:0] CfgHashSeed   = 1'b1;

    typedef enum logic [1:0] {
        PH_SPACE  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // Datapath operation sequence
    typedef enum logic [3:0] {
        ST_IDLE,   // wait for a byte
        ST_MIX1,   // block scramble multiply 1
        ST_MIX2,   // block scramble multiply 2
        ST_MIX3,   // accumulator update
        ST_FIN0,   // tail scramble multiply 1
        ST_FIN1,   // tail scramble multiply 2, length xor
        ST_FIN2,   // finalization multiply 1
        ST_FIN3,   // finalization multiply 2
        ST_SEL,    // choose magnitude
        ST_DIV,    // restoring modulo, one bit per cycle
        ST_OUT     // result held
    } t_state;

    typedef struct packed {
        logic load_byte;   // take input beat into parser and block buffer
        logic empty_load;  // empty feature: restart with seed
        logic mix1;
        logic mix2;
        logic mix3;
        logic fin0;
        logic fin1;
        logic fin2;
        logic fin3;
        logic sel;
        logic div_step;
        logic clear;       // feature finished
    } t_cmd;

    typedef struct packed {
        logic block_full;  // fourth byte of a block taken
        logic div_done;
    } t_status;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction
endpackage
`default_nettype wire

// ===== rtl/fhb_ctrl.sv =====
`default_nettype none
module fhb_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_beat,
    input  wire logic           i_last,
    input  wire logic           i_empty,
    input  wire logic           i_out_beat,
    input  wire fhb_pkg::t_status i_status,
    output fhb_pkg::t_cmd       o_cmd,
    output logic                o_in_ready,
    output logic                o_out_valid
);
    import fhb_pkg::*;
    `include "feature_hash_bucket_unit_assert.svh"

    t_state r_state, n_state;
    logic   r_last, n_last;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_beat) begin
                    if (i_empty) begin
                        o_cmd.empty_load = 1'b1;
                        n_state = ST_FIN2;
                    end else begin
                        o_cmd.load_byte = 1'b1;
                        n_last = i_last;
                        if (i_status.block_full) n_state = ST_MIX1;
                        else if (i_last) n_state = ST_FIN0;
                    end
                end
            end
            ST_MIX1: begin
                o_cmd.mix1 = 1'b1;
                n_state = ST_MIX2;
            end
            ST_MIX2: begin
                o_cmd.mix2 = 1'b1;
                n_state = ST_MIX3;
            end
            ST_MIX3: begin
                o_cmd.mix3 = 1'b1;
                n_state = r_last ? ST_FIN0 : ST_IDLE;
            end
            ST_FIN0: begin
                o_cmd.fin0 = 1'b1;
                n_state = ST_FIN1;
            end
            ST_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state = ST_FIN2;
            end
            ST_FIN2: begin
                o_cmd.fin2 = 1'b1;
                n_state = ST_FIN3;
            end
            ST_FIN3: begin
                o_cmd.fin3 = 1'b1;
                n_state = ST_SEL;
            end
            ST_SEL: begin
                o_cmd.sel = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_beat) begin
                    o_cmd.clear = 1'b1;
                    n_last  = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `FHB_ASSERT_IMP(a_ready_only_idle, i_clk, i_rst_n, o_in_ready, !o_out_valid, "ready with result")
    `FHB_ASSERT_NEXT(a_out_follows_div, i_clk, i_rst_n, (r_state == ST_DIV) && i_status.div_done, o_out_valid, "no result after modulo")
    `FHB_ASSERT_NEXT(a_empty_to_final, i_clk, i_rst_n, i_in_beat && i_empty, r_state == ST_FIN2, "empty feature skipped finalization")
endmodule
`default_nettype wire

// ===== rtl/fhb_datapath.sv =====
`default_nettype none
module fhb_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire fhb_pkg::t_cmd i_cmd,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_cfg_we,
    input  wire logic [0:0]    i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data,
    output fhb_pkg::t_status   o_status,
    output logic [31:0]        o_bucket_index,
    output logic               o_sign_negative,
    output logic               o_used_number,
    output logic [31:0]        o_raw_hash
);
    import fhb_pkg::*;

    logic [31:0] r_num_buckets, r_seed;
    logic [31:0] r_accum, r_k, r_h;
    logic [23:0] r_pend;
    logic [LengthBits-1:0] r_count;
    t_phase      r_phase;
    logic [63:0] r_mag;
    logic        r_neg, r_verdict, r_empty;
    logic [63:0] r_dividend;
    logic [32:0] r_rem;
    logic [6:0]  r_bits;
    logic        r_out_neg, r_out_num;

    // byte classification
    logic        is_digit, is_space, first;
    logic [3:0]  digit;
    logic [63:0] lim, cur_mag, mag10;
    logic [1:0]  pos;
    logic [31:0] block_word, acc_base;
    logic        num_sel;

    assign is_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign is_space = (i_byte == 8'h20) || ((i_byte >= 8'h09) && (i_byte <= 8'h0D));
    assign digit    = 4'(i_byte - 8'h30);
    assign first    = (r_count == '0);
    assign pos      = r_count[1:0];
    assign lim      = r_neg ? NegLimit : PosLimit;
    assign cur_mag  = first ? 64'd0 : r_mag;
    assign mag10    = (cur_mag << 3) + (cur_mag << 1);
    assign acc_base = first ? r_seed : r_accum;
    assign block_word = {i_byte, r_pend};
    assign o_status.block_full = (pos == 2'd3);
    assign o_status.div_done   = (r_bits == 7'd0);

    // numeric verdict at the end of the feature
    assign num_sel = (r_phase == PH_DONE) ? r_verdict : (r_phase == PH_DIGITS);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_buckets <= NumBucketsReset;
            r_seed        <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CfgNumBuckets) r_num_buckets <= i_cfg_data;
            else r_seed <= i_cfg_data;
        end
    end

    // parse and hash state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count <= '0;
            r_phase <= PH_SPACE;
            r_neg   <= 1'b0;
            r_verdict <= 1'b0;
            r_mag   <= '0;
            r_pend  <= '0;
            r_accum <= '0;
            r_empty <= 1'b0;
        end else if (i_cmd.empty_load) begin
            r_empty <= 1'b1;
            r_h     <= r_seed;
        end else if (i_cmd.load_byte) begin
            r_accum <= acc_base;
            r_count <= r_count + 1'b1;
            if (pos == 2'd3) begin
                r_k    <= block_word;
                r_pend <= '0;
            end else begin
                r_pend <= r_pend | (24'(i_byte) << (5'd8 * 5'(pos)));
            end
            // strtol-style scan
            if (first) begin
                r_mag <= '0;
            end
            case (first ? PH_SPACE : r_phase)
                PH_SPACE: begin
                    if (is_space) begin
                    end else if (i_byte == 8'h2B || i_byte == 8'h2D) begin
                        r_neg   <= (i_byte == 8'h2D);
                        r_phase <= PH_SIGN;
                    end else if (!is_digit) begin
                        r_phase   <= PH_DONE;
                        r_verdict <= (i_byte == 8'h00) && first;
                    end
                end
                PH_SIGN: begin
                    if (!is_digit) begin
                        r_phase <= PH_DONE;
                        r_verdict <= 1'b0;
                    end
                end
                PH_DIGITS: begin
                    if (!is_digit) begin
                        r_phase <= PH_DONE;
                        r_verdict <= (i_byte == 8'h00);
                    end
                end
                default: ;
            endcase
            if (is_digit && (first || r_phase != PH_DONE)) begin
                r_phase <= PH_DIGITS;
                // overflow check: mag*10 + d > lim; only the top magnitude
                // needs the digit, whose limit is 7 positive and 8 negative
                if (cur_mag > 64'h0CCC_CCCC_CCCC_CCCC
                    || (cur_mag == 64'h0CCC_CCCC_CCCC_CCCC
                        && digit > (r_neg ? 4'd8 : 4'd7)))
                    r_mag <= lim;
                else
                    r_mag <= mag10 + 64'(digit);
            end
        end else if (i_cmd.mix1) begin
            r_k <= r_k * MhC1;
        end else if (i_cmd.mix2) begin
            r_k <= rotl(r_k, 15) * MhC2;
        end else if (i_cmd.mix3) begin
            r_accum <= (rotl(r_accum ^ r_k, 13) * 32'd5) + MhAdd;
        end else if (i_cmd.fin0) begin
            r_k <= {8'd0, r_pend} * MhC1;
        end else if (i_cmd.fin1) begin
            r_h <= (r_accum ^ ((r_count[1:0] != 2'd0) ? rotl(r_k, 15) * MhC2 : 32'd0))
                   ^ 32'(r_count);
        end else if (i_cmd.fin2) begin
            r_h <= (r_h ^ (r_h >> 16)) * MhF1;
        end else if (i_cmd.fin3) begin
            r_h <= ((r_h ^ (r_h >> 13)) * MhF2);
        end else if (i_cmd.sel) begin
            r_h <= r_h ^ (r_h >> 16);
        end
    end

    // magnitude select and bit-serial modulo
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
        end else if (i_cmd.sel) begin
            logic [31:0] hf;
            hf = r_h ^ (r_h >> 16);
            r_rem <= '0;
            r_bits <= 7'd64;
            if (r_empty) begin
                r_dividend <= '0;
                r_out_neg  <= 1'b0;
                r_out_num  <= 1'b1;
            end else if (num_sel) begin
                r_dividend <= r_mag;
                r_out_neg  <= r_neg && (r_mag != '0);
                r_out_num  <= 1'b1;
            end else begin
                r_dividend <= hf[31] ? 64'(33'h1_0000_0000 - 33'(hf)) : 64'(hf);
                r_out_neg  <= hf[31];
                r_out_num  <= 1'b0;
            end
        end else if (i_cmd.div_step && r_bits != '0) begin
            logic [32:0] t;
            t = {r_rem[31:0], r_dividend[63]};
            r_dividend <= {r_dividend[62:0], 1'b0};
            r_bits <= r_bits - 1'b1;
            if (r_num_buckets == '0) r_rem <= {1'b0, t[31:0]};
            else if (t >= {1'b0, r_num_buckets}) r_rem <= t - {1'b0, r_num_buckets};
            else r_rem <= t;
        end
    end

    assign o_bucket_index  = r_rem[31:0];
    assign o_sign_negative = r_out_neg;
    assign o_used_number   = r_out_num;
    assign o_raw_hash      = r_h;
endmodule
`default_nettype wire

// ===== rtl/feature_hash_bucket_unit.sv =====
// Feature hash bucket unit. Each input beat carries one byte of a feature
// string; the beat with last set (or an empty-feature beat) produces one
// result beat. After each fourth byte the block is mixed in the states MIX1,
// MIX2 and MIX3 (one 32x32 multiplier per step). The end of a feature runs the
// finalization states FIN0 to FIN3 (only FIN2 and FIN3 for an empty feature),
// a select state, a bit-serial modulo by the bucket count and a state holding
// the result beat; no new byte is taken until that beat is accepted.
// Configuration writes are accepted at any time but must only be made while
// idle.
`default_nettype none
module feature_hash_bucket_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // data_byte
    input  wire logic        s_axis_tlast,  // last_byte
    input  wire logic        s_axis_tuser,  // empty_feature
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // bucket_index[31:0], raw_hash[63:32]
    output logic [1:0]       m_axis_tuser,  // sign_negative[0], used_number[1]
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import fhb_pkg::*;

    t_cmd        cmd;
    t_status     status;
    logic [31:0] bucket, raw;
    logic        neg, num;

    assign o_cfg_ready = 1'b1;

    fhb_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_beat  (s_axis_tvalid && s_axis_tready),
        .i_last     (s_axis_tlast),
        .i_empty    (s_axis_tuser),
        .i_out_beat (m_axis_tvalid && m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid)
    );

    fhb_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_cmd          (cmd),
        .i_byte         (s_axis_tdata),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_idx      (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_status       (status),
        .o_bucket_index (bucket),
        .o_sign_negative(neg),
        .o_used_number  (num),
        .o_raw_hash     (raw)
    );

    assign m_axis_tdata = {raw, bucket};
    assign m_axis_tuser = {num, neg};
endmodule
`default_nettype wire
